### design/bre_pkg.sv
package bre_pkg;

    // Command codes carried on the func field
    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    // Line direction flags worked out at load time
    typedef struct packed {
        logic steep;
        logic minor_backward;
    } t_step_ctl;

endpackage

### design/bre_loader.sv
module bre_loader #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output bre_pkg::t_step_ctl    o_ctl,
    output logic [COORD_BITS-1:0] o_start_col,
    output logic [COORD_BITS-1:0] o_start_row,
    output logic [COORD_BITS-1:0] o_major_delta,
    output logic [COORD_BITS-1:0] o_minor_delta
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  steep;
    logic                  keep_order;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;

    // Absolute deltas on each axis
    assign dx = (i_x_start > i_x_end) ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
    assign dy = (i_y_start > i_y_end) ? (i_y_start - i_y_end) : (i_y_end - i_y_start);

    // Equal magnitudes count as steep
    assign steep = !(dx > dy);

    // Start from the endpoint lower on the major axis
    assign keep_order = steep ? (i_y_end > i_y_start) : (i_x_end > i_x_start);

    always_comb begin
        if (keep_order) begin
            o_start_col = i_x_start;
            o_start_row = i_y_start;
            ex          = i_x_end;
            ey          = i_y_end;
        end else begin
            o_start_col = i_x_end;
            o_start_row = i_y_end;
            ex          = i_x_start;
            ey          = i_y_start;
        end
    end

    // Major and minor axis set-up
    always_comb begin
        o_ctl.steep = steep;
        if (steep) begin
            o_major_delta        = dy;
            o_minor_delta        = dx;
            o_ctl.minor_backward = ex < o_start_col;
        end else begin
            o_major_delta        = dx;
            o_minor_delta        = dy;
            o_ctl.minor_backward = ey < o_start_row;
        end
    end

endmodule

### design/bre_stepper.sv
module bre_stepper #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_func,
    input  bre_pkg::t_step_ctl    i_ctl,
    input  logic [COORD_BITS-1:0] i_start_col,
    input  logic [COORD_BITS-1:0] i_start_row,
    input  logic [COORD_BITS-1:0] i_major_delta,
    input  logic [COORD_BITS-1:0] i_minor_delta,
    output logic                  o_produce,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);

    localparam int EW = COORD_BITS + 3;

    logic                   r_busy;
    logic [COORD_BITS-1:0]  r_cur_col;
    logic [COORD_BITS-1:0]  r_cur_row;
    logic signed [EW-1:0]   r_err;
    logic [COORD_BITS-1:0]  r_left;
    bre_pkg::t_step_ctl     r_ctl;
    logic [COORD_BITS-1:0]  r_major;
    logic [COORD_BITS-1:0]  r_minor;

    logic                   n_busy;
    logic [COORD_BITS-1:0]  n_cur_col;
    logic [COORD_BITS-1:0]  n_cur_row;
    logic signed [EW-1:0]   n_err;
    logic [COORD_BITS-1:0]  n_left;
    bre_pkg::t_step_ctl     n_ctl;
    logic [COORD_BITS-1:0]  n_major;
    logic [COORD_BITS-1:0]  n_minor;

    logic                   is_load;
    logic                   is_tick;
    logic                   last;
    logic                   err_pos;
    logic signed [EW-1:0]   inc_flat;
    logic signed [EW-1:0]   inc_diag;
    logic signed [EW-1:0]   load_err;
    logic [COORD_BITS-1:0]  minor_cur;
    logic [COORD_BITS-1:0]  minor_nxt;

    assign is_load = (i_func == bre_pkg::FUNC_LOAD);
    assign is_tick = (i_func == bre_pkg::FUNC_TICK);
    assign last    = (r_left == '0);

    // A tick yields a word only while a line is running
    assign o_produce    = is_tick && r_busy;
    assign o_pixel_x    = r_cur_col;
    assign o_pixel_y    = r_cur_row;
    assign o_last_pixel = last;

    // Error term arithmetic
    assign err_pos  = !r_err[EW-1] && (r_err != '0);
    assign inc_flat = $signed({2'b00, r_minor, 1'b0});
    assign inc_diag = $signed({2'b00, r_minor, 1'b0}) - $signed({2'b00, r_major, 1'b0});
    assign load_err = $signed({2'b00, i_minor_delta, 1'b0}) - $signed({3'b000, i_major_delta});

    // Minor axis step toward its end
    assign minor_cur = r_ctl.steep ? r_cur_col : r_cur_row;
    assign minor_nxt = r_ctl.minor_backward ? (minor_cur - 1'b1) : (minor_cur + 1'b1);

    // Next state
    always_comb begin
        n_busy    = r_busy;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_err     = r_err;
        n_left    = r_left;
        n_ctl     = r_ctl;
        n_major   = r_major;
        n_minor   = r_minor;
        if (i_en && is_load) begin
            n_busy    = 1'b1;
            n_cur_col = i_start_col;
            n_cur_row = i_start_row;
            n_err     = load_err;
            n_left    = i_major_delta;
            n_ctl     = i_ctl;
            n_major   = i_major_delta;
            n_minor   = i_minor_delta;
        end else if (i_en && o_produce) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_left = r_left - 1'b1;
                if (r_ctl.steep) begin
                    n_cur_row = r_cur_row + 1'b1;
                    if (err_pos) begin
                        n_cur_col = minor_nxt;
                    end
                end else begin
                    n_cur_col = r_cur_col + 1'b1;
                    if (err_pos) begin
                        n_cur_row = minor_nxt;
                    end
                end
                n_err = r_err + (err_pos ? inc_diag : inc_flat);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_err     <= '0;
            r_left    <= '0;
            r_ctl     <= '0;
            r_major   <= '0;
            r_minor   <= '0;
        end else begin
            r_busy    <= n_busy;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_err     <= n_err;
            r_left    <= n_left;
            r_ctl     <= n_ctl;
            r_major   <= n_major;
            r_minor   <= n_minor;
        end
    end

    // A load always starts a line
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && is_load |=> r_busy)
        else $error("load did not start a line");

    // The final pixel ends the line
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_produce && last |=> !r_busy)
        else $error("line still busy after last pixel");

    // Shallow lines advance one column per pixel
    a_shallow_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_produce && !last && !r_ctl.steep
        |=> r_cur_col == COORD_BITS'($past(r_cur_col) + 1'b1))
        else $error("shallow step did not advance column");

endmodule

### design/bresenham_line_rasterizer_top.sv
// A tick is accepted into the input register; when it moves on, the stepper steps the line and
// its pixel word is written into the output register at the same edge.
// Throughput: one command or tick per cycle while the output register is not stalled; the
// single Bresenham add/compare step between the input and output registers sets that figure.
// Reset (synchronous, active low): no line in progress, both registers empty.
module bresenham_line_rasterizer_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);

    logic                  r_in_valid;
    logic                  r_func;
    logic [COORD_BITS-1:0] r_x_start;
    logic [COORD_BITS-1:0] r_y_start;
    logic [COORD_BITS-1:0] r_x_end;
    logic [COORD_BITS-1:0] r_y_end;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_pixel_x;
    logic [COORD_BITS-1:0] r_pixel_y;
    logic                  r_last_pixel;

    bre_pkg::t_step_ctl    ctl;
    logic [COORD_BITS-1:0] start_col;
    logic [COORD_BITS-1:0] start_row;
    logic [COORD_BITS-1:0] major_delta;
    logic [COORD_BITS-1:0] minor_delta;
    logic                  produce;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;
    logic                  step_last;
    logic                  adv;

    // Held word moves on unless it makes a pixel and the output slot is full and not being read
    assign adv     = r_in_valid && (!produce || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_func    <= i_func;
            r_x_start <= i_x_start;
            r_y_start <= i_y_start;
            r_x_end   <= i_x_end;
            r_y_end   <= i_y_end;
        end
    end

    bre_loader #(
        .COORD_BITS (COORD_BITS)
    ) u_loader (
        .i_x_start     (r_x_start),
        .i_y_start     (r_y_start),
        .i_x_end       (r_x_end),
        .i_y_end       (r_y_end),
        .o_ctl         (ctl),
        .o_start_col   (start_col),
        .o_start_row   (start_row),
        .o_major_delta (major_delta),
        .o_minor_delta (minor_delta)
    );

    bre_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv),
        .i_func        (r_func),
        .i_ctl         (ctl),
        .i_start_col   (start_col),
        .i_start_row   (start_row),
        .i_major_delta (major_delta),
        .i_minor_delta (minor_delta),
        .o_produce     (produce),
        .o_pixel_x     (step_x),
        .o_pixel_y     (step_y),
        .o_last_pixel  (step_last)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && produce) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && produce) begin
            r_pixel_x    <= step_x;
            r_pixel_y    <= step_y;
            r_last_pixel <= step_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_x    = r_pixel_x;
    assign o_pixel_y    = r_pixel_y;
    assign o_last_pixel = r_last_pixel;

    // A stalled pixel word must not be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |-> !(adv && produce))
        else $error("pixel word overwritten while stalled");

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = 12;
    localparam int CMAX_I      = (1 << CW) - 1;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_WORDS = 230;
    localparam int IDLE_PLAN[4]  = '{0, 46, 0, 20};
    localparam int STALL_PLAN[4] = '{0, 0, 46, 20};

    typedef struct packed {
        bre_pkg::t_func  func;
        logic [CW-1:0]   xs;
        logic [CW-1:0]   ys;
        logic [CW-1:0]   xe;
        logic [CW-1:0]   ye;
    } t_cmd;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } t_pixel;

    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_NONE,
        EXP_PIXEL
    } t_exp_kind;

    typedef struct {
        t_cmd      cmd;
        t_exp_kind kind;
        t_pixel    px;
    } t_step_row;

    logic          i_clk     = 1'b0;
    logic          i_rst_n   = 1'b0;
    logic          i_valid   = 1'b0;
    logic          i_func    = 1'b0;
    logic [CW-1:0] i_x_start = '0;
    logic [CW-1:0] i_y_start = '0;
    logic [CW-1:0] i_x_end   = '0;
    logic [CW-1:0] i_y_end   = '0;
    logic          i_ready   = 1'b0;
    logic          o_ready;
    logic          o_valid;
    logic [CW-1:0] o_pixel_x;
    logic [CW-1:0] o_pixel_y;
    logic          o_last_pixel;

    bresenham_line_rasterizer_top #(
        .COORD_BITS(CW)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last_pixel(o_last_pixel)
    );

    always #6 i_clk = ~i_clk;

    // Line tracer state, mirrors the block after reset
    logic          line_busy  = 1'b0;
    logic [CW-1:0] next_col   = '0;
    logic [CW-1:0] next_row   = '0;
    logic [CW-1:0] steps_left = '0;
    logic [CW-1:0] major_len  = '0;
    logic [CW-1:0] minor_len  = '0;
    logic          y_major    = 1'b0;
    logic          minor_down = 1'b0;
    int            decision   = 0;

    t_pixel      pending_pixels[$];
    int unsigned mismatches     = 0;
    int unsigned words_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_reqs      = 0;
    int          hold_seen      = 0;

    // Apply one word to the tracer; returns 1 when a pixel comes out
    function automatic logic plot_word(input t_cmd c, output t_pixel px);
        logic [CW-1:0] dx;
        logic [CW-1:0] dy;
        px = '0;
        if (c.func == bre_pkg::FUNC_LOAD) begin
            dx = (c.xs > c.xe) ? c.xs - c.xe : c.xe - c.xs;
            dy = (c.ys > c.ye) ? c.ys - c.ye : c.ye - c.ys;
            y_major = !(dx > dy);
            if (!y_major) begin
                major_len = dx;
                minor_len = dy;
                // shallow: start from the smaller x
                if (c.xe > c.xs) begin
                    next_col   = c.xs;
                    next_row   = c.ys;
                    minor_down = c.ye < c.ys;
                end else begin
                    next_col   = c.xe;
                    next_row   = c.ye;
                    minor_down = c.ys < c.ye;
                end
            end else begin
                major_len = dy;
                minor_len = dx;
                // steep or diagonal: start from the smaller y
                if (c.ye > c.ys) begin
                    next_col   = c.xs;
                    next_row   = c.ys;
                    minor_down = c.xe < c.xs;
                end else begin
                    next_col   = c.xe;
                    next_row   = c.ye;
                    minor_down = c.xs < c.xe;
                end
            end
            decision   = 2 * int'(minor_len) - int'(major_len);
            steps_left = major_len;
            line_busy  = 1'b1;
            return 1'b0;
        end
        if (!line_busy)
            return 1'b0;

        px.x    = next_col;
        px.y    = next_row;
        px.last = (steps_left == '0);
        if (px.last) begin
            line_busy = 1'b0;
            return 1'b1;
        end

        // major axis always moves up by one
        if (y_major)
            next_row = next_row + 1'b1;
        else
            next_col = next_col + 1'b1;

        // minor axis follows the error term
        if (decision > 0) begin
            if (y_major)
                next_col = minor_down ? next_col - 1'b1 : next_col + 1'b1;
            else
                next_row = minor_down ? next_row - 1'b1 : next_row + 1'b1;
            decision += 2 * (int'(minor_len) - int'(major_len));
        end else begin
            decision += 2 * int'(minor_len);
        end
        steps_left = steps_left - 1'b1;
        return 1'b1;
    endfunction

    function automatic t_step_row mk_row(bre_pkg::t_func f, int xs, int ys, int xe, int ye,
                                         t_exp_kind k, int px = 0, int py = 0, int pl = 0);
        t_step_row r;
        r.cmd.func = f;
        r.cmd.xs   = xs[CW-1:0];
        r.cmd.ys   = ys[CW-1:0];
        r.cmd.xe   = xe[CW-1:0];
        r.cmd.ye   = ye[CW-1:0];
        r.kind     = k;
        r.px.x     = px[CW-1:0];
        r.px.y     = py[CW-1:0];
        r.px.last  = pl[0];
        return r;
    endfunction

    function automatic t_cmd rand_cmd(bre_pkg::t_func f);
        t_cmd c;
        c.func = f;
        c.xs   = CW'($urandom_range(CMAX_I));
        c.ys   = CW'($urandom_range(CMAX_I));
        c.xe   = CW'($urandom_range(CMAX_I));
        c.ye   = CW'($urandom_range(CMAX_I));
        return c;
    endfunction

    // Coordinate within span of base, clipped to the screen
    function automatic logic [CW-1:0] near(int base, int span);
        int v;
        v = base + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > CMAX_I)
            v = CMAX_I;
        return v[CW-1:0];
    endfunction

    // Short line somewhere on screen, now and then hugging an edge or axis-aligned
    function automatic t_cmd line_cmd(int span);
        t_cmd c;
        int   bx;
        int   by;
        int   r;
        case ($urandom_range(9))
            0:       bx = 0;
            1:       bx = CMAX_I;
            default: bx = $urandom_range(CMAX_I);
        endcase
        case ($urandom_range(9))
            0:       by = 0;
            1:       by = CMAX_I;
            default: by = $urandom_range(CMAX_I);
        endcase
        c.func = bre_pkg::FUNC_LOAD;
        c.xs   = near(bx, span);
        c.ys   = near(by, span);
        c.xe   = near(int'(c.xs), span);
        c.ye   = near(int'(c.ys), span);
        r = $urandom_range(7);
        if (r == 0)
            c.ye = c.ys;
        else if (r == 1)
            c.xe = c.xs;
        return c;
    endfunction

    // Offer one word, wait for the handshake, then log what it should produce
    task automatic send_word(input t_cmd c, input t_exp_kind kind = EXP_PREDICT,
                             input t_pixel typed = '0);
        t_pixel px;
        logic   got;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid   <= 1'b1;
        i_func    <= c.func;
        i_x_start <= c.xs;
        i_y_start <= c.ys;
        i_x_end   <= c.xe;
        i_y_end   <= c.ye;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        got = plot_word(c, px);
        case (kind)
            EXP_PREDICT: if (got) pending_pixels.push_back(px);
            EXP_PIXEL:   pending_pixels.push_back(typed);
            default:     ;
        endcase
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(rand_cmd(bre_pkg::FUNC_TICK));
    endtask

    task automatic drain_pixels();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
    endtask

    task automatic run_random(int n);
        int stop;
        int r;
        stop = words_sent + n;
        while (words_sent < stop) begin
            r = $urandom_range(99);
            if (r < 62) begin
                // whole short line, sometimes with idle ticks after it
                send_word(line_cmd($urandom_range(1, 24)));
                send_ticks(int'(major_len) + 1
                           + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0));
            end else if (r < 74) begin
                // cut short by the next load
                send_word(line_cmd(24));
                send_ticks($urandom_range(int'(major_len)));
            end else if (r < 84) begin
                // long line anywhere, only its first pixels
                send_word(rand_cmd(bre_pkg::FUNC_LOAD));
                send_ticks($urandom_range(1, 30));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_word(rand_cmd(bre_pkg::t_func'($urandom_range(1))));
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Pixel word checker
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel word: x=%0d y=%0d last=%0d",
                       o_pixel_x, o_pixel_y, o_last_pixel);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_x !== want.x) begin
                    $error("pixel_x: expected %0d, got %0d", want.x, o_pixel_x);
                    mismatches++;
                end
                if (o_pixel_y !== want.y) begin
                    $error("pixel_y: expected %0d, got %0d", want.y, o_pixel_y);
                    mismatches++;
                end
                if (o_last_pixel !== want.last) begin
                    $error("last_pixel: expected %0d, got %0d", want.last, o_last_pixel);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_step_row directed_steps[$];
        t_step_row hold_row;

        // tick while idle, then single-pixel lines at both corners
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_NONE));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_LOAD, 0, 0, 0, 0, EXP_NONE));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PIXEL, 0, 0, 1));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_NONE));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_LOAD, CMAX_I, CMAX_I, CMAX_I, CMAX_I,
                                        EXP_NONE));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PIXEL,
                                        CMAX_I, CMAX_I, 1));
        // full-screen diagonal, replaced after two pixels
        directed_steps.push_back(mk_row(bre_pkg::FUNC_LOAD, CMAX_I, 0, 0, CMAX_I, EXP_NONE));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PIXEL,
                                        CMAX_I, 0, 0));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PREDICT));
        // horizontal at the right edge, given right to left
        directed_steps.push_back(mk_row(bre_pkg::FUNC_LOAD, CMAX_I, 5, CMAX_I - 3, 5,
                                        EXP_NONE));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PIXEL,
                                        CMAX_I - 3, 5, 0));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PREDICT));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PREDICT));
        directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PIXEL,
                                        CMAX_I, 5, 1));
        // shallow, minor axis falling
        directed_steps.push_back(mk_row(bre_pkg::FUNC_LOAD, 0, 9, 3, 7, EXP_NONE));
        repeat (4)
            directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PREDICT));
        // steep, minor axis falling
        directed_steps.push_back(mk_row(bre_pkg::FUNC_LOAD, 2, 0, 0, 4, EXP_NONE));
        repeat (5)
            directed_steps.push_back(mk_row(bre_pkg::FUNC_TICK, 0, 0, 0, 0, EXP_PREDICT));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i])
            send_word(directed_steps[i].cmd, directed_steps[i].kind, directed_steps[i].px);

        // long receiver hold-off while a 200-pixel line keeps the input busy
        hold_reqs <= hold_reqs + 1;
        hold_row = mk_row(bre_pkg::FUNC_LOAD, CMAX_I, 0, CMAX_I - 199, 57, EXP_NONE);
        send_word(hold_row.cmd);
        send_ticks(200);
        drain_pixels();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct   = IDLE_PLAN[p];
            recv_stall_pct <= STALL_PLAN[p];
            run_random(PHASE_WORDS);
            drain_pixels();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
design/bre_pkg.sv
design/bre_loader.sv
design/bre_stepper.sv
design/bresenham_line_rasterizer_top.sv
dv/tb.sv
